/* rtl/bsst_pkg.sv */
`timescale 1ns / 1ps

package bsst_pkg;

	localparam int STORE_DEPTH_DEF = 64;
	localparam int CAP_W           = 7;
	localparam int DATA_W          = 32;
	localparam int PADDR_W         = 3;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_MIN  = 2'd1,
		OP_MAX  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_FEW  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_CMP,
		S_ADD_FIN,
		S_MIN_SCAN,
		S_MAX_A,
		S_MAX_B,
		S_MAX_C,
		S_RESP
	} state_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic signed [DATA_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   span;
	} res_item_t;

endpackage

/* rtl/bounded_set_span_tracker_top.sv */
`timescale 1ns / 1ps

// Bounded set span tracker: holds up to min(capacity, STORE_DEPTH) signed
// 32-bit values in ascending order and answers span queries over them.
// Command channel (cmd_valid/cmd_ready/cmd): opcode add, shortest or longest.
// Result channel (res_valid/res_ready/res): one status and span per command.
// Capacity lives at APB byte address 0; pready is tied high.
// Command handling walks the store (one read and one write port) one entry per cycle:
//   add: sorted insertion shifts every held value larger than the new one
//   up by one entry each cycle, and an empty set takes the value directly;
//   shortest: linear scan of neighbouring pairs;
//   longest: reads the first and last held values; rejected or unused
//   commands go straight to the result.
// Results land in an output register, so the next command transfer is taken
// while a finished result still waits for res_ready. If the receiver stalls
// with that register full, the engine holds its next result and stops
// taking commands until the register drains.
// Reset clears capacity and the held count; the store itself is not cleared
// and needs no sweep.
module bounded_set_span_tracker_top #(
	parameter int STORE_DEPTH = bsst_pkg::STORE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  bsst_pkg::cmd_item_t           cmd,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bsst_pkg::res_item_t           res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bsst_pkg::PADDR_W-1:0]  paddr,
	input  logic [bsst_pkg::DATA_W-1:0]   pwdata,
	output logic [bsst_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [bsst_pkg::CAP_W-1:0] capacity_q;
	logic                       res_valid_q;
	bsst_pkg::res_item_t        res_q;
	logic                       core_valid, core_ready;
	bsst_pkg::res_item_t        core_res;
	logic                       cap_sel;

	// register index is the word address; only index 0 exists
	assign cap_sel = (paddr[bsst_pkg::PADDR_W-1:2] == '0);
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? bsst_pkg::DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (psel && penable && pwrite && cap_sel) begin
			capacity_q <= pwdata[bsst_pkg::CAP_W-1:0];
		end
	end

	bsst_core #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res)
	);

	// output register: take a new result whenever the slot is empty or draining
	assign core_ready = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_valid && core_ready) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// hold the payload until the transfer completes
	always_ff @(posedge clk) begin
		if (core_valid && core_ready)
			res_q <= core_res;
	end

endmodule

/* rtl/bsst_core.sv */
`timescale 1ns / 1ps

module bsst_core #(
	parameter int STORE_DEPTH = bsst_pkg::STORE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bsst_pkg::CAP_W-1:0]  capacity,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  bsst_pkg::cmd_item_t         cmd,
	output logic                        res_valid,
	input  logic                        res_ready,
	output bsst_pkg::res_item_t         res
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int LW = (CW > bsst_pkg::CAP_W) ? CW : bsst_pkg::CAP_W;
	localparam int DW = bsst_pkg::DATA_W;

	bsst_pkg::state_t state_q, state_d;

	logic [DW-1:0]         mem [STORE_DEPTH];
	logic [DW-1:0]         rd_data_s1;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa, mem_ra;
	logic [DW-1:0]         mem_wd;

	logic [CW-1:0]         count_q, pos_q, ptr_q;
	logic [AW-1:0]         idx_s1;
	logic                  vld_s1;
	logic signed [DW-1:0]  val_q;
	logic [DW-1:0]         prev_q, best_q;
	bsst_pkg::res_item_t   res_q;

	logic                  full, few, gt, last, more;
	logic [CW-1:0]         pos_m1;
	logic [AW-1:0]         last_idx;
	logic [DW-1:0]         diff, best_new;

	assign full     = (LW'(count_q) >= LW'(capacity)) || (count_q == CW'(STORE_DEPTH));
	assign few      = count_q < CW'(2);
	assign pos_m1   = pos_q - CW'(1);
	assign last_idx = AW'(count_q - CW'(1));
	assign gt       = $signed(rd_data_s1) > val_q;
	assign diff     = rd_data_s1 - prev_q;
	assign best_new = (diff < best_q) ? diff : best_q;
	assign last     = vld_s1 && (idx_s1 == last_idx);
	assign more     = ptr_q < count_q;
	assign res      = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsst_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.opcode)
						bsst_pkg::OP_ADD: begin
							if (full)
								state_d = bsst_pkg::S_RESP;
							else if (count_q == '0)
								state_d = bsst_pkg::S_ADD_FIN;
							else
								state_d = bsst_pkg::S_ADD_RD;
						end
						bsst_pkg::OP_MIN: state_d = few ? bsst_pkg::S_RESP : bsst_pkg::S_MIN_SCAN;
						bsst_pkg::OP_MAX: state_d = few ? bsst_pkg::S_RESP : bsst_pkg::S_MAX_A;
						default:          state_d = bsst_pkg::S_RESP;
					endcase
				end
			end
			bsst_pkg::S_ADD_RD:  state_d = bsst_pkg::S_ADD_CMP;
			bsst_pkg::S_ADD_CMP: begin
				if (!gt)
					state_d = bsst_pkg::S_RESP;
				else if (pos_m1 == '0)
					state_d = bsst_pkg::S_ADD_FIN;
			end
			bsst_pkg::S_ADD_FIN:  state_d = bsst_pkg::S_RESP;
			bsst_pkg::S_MIN_SCAN: if (last) state_d = bsst_pkg::S_RESP;
			bsst_pkg::S_MAX_A:    state_d = bsst_pkg::S_MAX_B;
			bsst_pkg::S_MAX_B:    state_d = bsst_pkg::S_MAX_C;
			bsst_pkg::S_MAX_C:    state_d = bsst_pkg::S_RESP;
			bsst_pkg::S_RESP:     if (res_ready) state_d = bsst_pkg::S_IDLE;
			default:              state_d = bsst_pkg::S_IDLE;
		endcase
	end

	// memory port control; shift writes and look-ahead reads never hit the same entry
	always_comb begin
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = pos_q[AW-1:0];
		mem_wd    = val_q;
		mem_ra    = '0;
		unique case (state_q)
			bsst_pkg::S_IDLE:     cmd_ready = 1'b1;
			bsst_pkg::S_ADD_RD:   mem_ra = pos_m1[AW-1:0];
			bsst_pkg::S_ADD_CMP: begin
				mem_we = 1'b1;
				mem_wd = gt ? rd_data_s1 : val_q;
				mem_ra = AW'(pos_q - CW'(2));
			end
			bsst_pkg::S_ADD_FIN:  mem_we = 1'b1;
			bsst_pkg::S_MIN_SCAN: mem_ra = ptr_q[AW-1:0];
			bsst_pkg::S_MAX_A:    mem_ra = '0;
			bsst_pkg::S_MAX_B:    mem_ra = last_idx;
			bsst_pkg::S_MAX_C:    mem_ra = '0;
			bsst_pkg::S_RESP:     res_valid = 1'b1;
			default:              mem_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_data_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsst_pkg::S_IDLE;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == bsst_pkg::S_MIN_SCAN) && more;
			if ((state_q == bsst_pkg::S_ADD_FIN) || ((state_q == bsst_pkg::S_ADD_CMP) && !gt))
				count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bsst_pkg::S_IDLE: begin
				if (cmd_valid) begin
					val_q       <= cmd.value;
					pos_q       <= count_q;
					ptr_q       <= '0;
					best_q      <= '1;
					res_q.span  <= '0;
					case (cmd.opcode) inside
						bsst_pkg::OP_ADD:
							res_q.status <= full ? bsst_pkg::STAT_FULL : bsst_pkg::STAT_OK;
						bsst_pkg::OP_MIN, bsst_pkg::OP_MAX:
							res_q.status <= few ? bsst_pkg::STAT_FEW : bsst_pkg::STAT_OK;
						default:
							res_q.status <= bsst_pkg::STAT_OK;
					endcase
				end
			end
			bsst_pkg::S_ADD_CMP: if (gt) pos_q <= pos_m1;
			bsst_pkg::S_MIN_SCAN: begin
				if (more)
					ptr_q <= ptr_q + CW'(1);
				idx_s1 <= ptr_q[AW-1:0];
				if (vld_s1) begin
					prev_q <= rd_data_s1;
					if (idx_s1 != '0)
						best_q <= best_new;
					if (last)
						res_q.span <= best_new;
				end
			end
			bsst_pkg::S_MAX_B: prev_q <= rd_data_s1;
			bsst_pkg::S_MAX_C: res_q.span <= diff;
			default: ;
		endcase
	end

endmodule

/* verif/bsst_span_checker.sv */
`timescale 1ns / 1ps

module bsst_span_checker
	import bsst_pkg::*;
#(
	parameter int                 DEPTH    = STORE_DEPTH_DEF,
	parameter logic [PADDR_W-1:0] CAP_ADDR = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  cmd_item_t          cmd,
	input  logic               res_valid,
	input  logic               res_ready,
	input  res_item_t          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 failures,
	output int                 pending,
	output int                 checked,
	output int                 held_now
);

	logic signed [DATA_W-1:0] held_vals [DEPTH];
	int                       held_total;
	logic [CAP_W-1:0]         capacity_q;
	res_item_t                due_results [$];
	res_item_t                want;
	int                       fail_total;
	int                       checked_total;

	// Apply one command to the shadow set and return the result it owes.
	function automatic res_item_t predict_span_result(cmd_item_t c);
		res_item_t         r;
		int                limit;
		int                pos;
		int                i;
		logic [DATA_W-1:0] gap;
		r.status = STAT_OK;
		r.span   = '0;
		limit    = (int'(capacity_q) > DEPTH) ? DEPTH : int'(capacity_q);
		case (c.opcode)
			OP_ADD: begin
				if (held_total >= limit) begin
					r.status = STAT_FULL;
				end else begin
					pos = held_total;
					while (pos > 0 && held_vals[pos-1] > c.value) begin
						held_vals[pos] = held_vals[pos-1];
						pos--;
					end
					held_vals[pos] = c.value;
					held_total++;
				end
			end
			OP_MIN: begin
				if (held_total < 2) begin
					r.status = STAT_FEW;
				end else begin
					r.span = '1;
					for (i = 1; i < held_total; i++) begin
						// ascending order keeps the wrapped difference exact
						gap = DATA_W'(held_vals[i] - held_vals[i-1]);
						if (gap < r.span)
							r.span = gap;
					end
				end
			end
			OP_MAX: begin
				if (held_total < 2)
					r.status = STAT_FEW;
				else
					r.span = DATA_W'(held_vals[held_total-1] - held_vals[0]);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_total    = 0;
			capacity_q    = '0;
			fail_total    = 0;
			checked_total = 0;
			due_results.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				capacity_q = pwdata[CAP_W-1:0];
			// check the result side first so a stray result is never masked
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected, got status %0d span %h",
						$time, res.status, res.span);
					fail_total++;
				end else begin
					want = due_results.pop_front();
					checked_total++;
					if (res.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, res.status);
						fail_total++;
					end
					if (res.span !== want.span) begin
						$display("%0t: span mismatch, expected %h, got %h",
							$time, want.span, res.span);
						fail_total++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				due_results.insert(due_results.size(), predict_span_result(cmd));
		end
		failures <= fail_total;
		pending  <= due_results.size();
		checked  <= checked_total;
		held_now <= held_total;
	end

endmodule

/* verif/bounded_set_span_tracker_top_tb.sv */
`timescale 1ns / 1ps

module bounded_set_span_tracker_top_tb;
	import bsst_pkg::*;

	localparam int                 DEPTH         = STORE_DEPTH_DEF;
	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = '0;
	localparam int                 PHASES        = 8;
	localparam int                 PHASE_ITEMS   = 160;
	localparam int                 LONG_HOLD     = 300;
	// a full-depth shortest scan is the slowest command
	localparam int                 TAIL_CYCLES   = DEPTH + 16;

	// Capacity per random phase: fill gradually, drop below the held count,
	// go past the depth so the limit saturates, then sit exactly at the depth.
	localparam int PHASE_CAP  [PHASES] = '{10, 24, 40, 48, 20, 127, 64, 64};
	// Phases with idling on either side; the last one must be clean.
	localparam bit PHASE_IDLE [PHASES] = '{1, 1, 0, 1, 1, 1, 1, 0};
	// Duplicates pin the shortest span at zero for good, so allow them late.
	localparam int DUP_PHASE          = 5;
	localparam int HOLD_PHASE         = 1;
	localparam int PAUSE_PHASE        = 3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	cmd_item_t          cmd;
	logic               res_valid;
	logic               res_ready;
	res_item_t          res;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int failures;
	int pending;
	int checked;
	int held_now;

	bit idle_on;
	bit hold_req;
	int n_add;
	int n_min;
	int n_max;
	int n_none;

	// every value offered for insertion, kept to pick duplicates from
	logic signed [DATA_W-1:0] offered_vals [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bounded_set_span_tracker_top #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bsst_span_checker #(
		.DEPTH   (DEPTH),
		.CAP_ADDR(CAPACITY_ADDR)
	) span_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.failures (failures),
		.pending  (pending),
		.checked  (checked),
		.held_now (held_now)
	);

	// Hard stop, several times the slowest legal run.
	initial begin
		#8_000_000;
		$display("** bounded_set_span_tracker_top: FAILED **");
		$finish;
	end

	// Result side: alternate random bursts of ready and stall, honour a long
	// hold-off when the stimulus asks for one, and hold ready high when idling
	// is off. Each pass sets ready once and then waits on the clock.
	initial begin
		res_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!idle_on || $urandom_range(0, 2) != 0) begin
				res_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Write the capacity register: setup cycle, then access cycle.
	task automatic cfg_capacity(input logic [CAP_W-1:0] cap);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= DATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid and wait until every owed result has been checked. The first
	// edge lets the checker count a transfer taken at the current edge.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Offer one command, idling first now and then, and hold it until the
	// transfer. Valid is left high so back-to-back commands keep it raised.
	task automatic send_cmd(input opcode_t op, input logic signed [DATA_W-1:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{opcode: op, value: v};
		do @(posedge clk); while (!cmd_ready);
		case (op)
			OP_ADD: begin
				n_add++;
				offered_vals.insert(offered_vals.size(), v);
			end
			OP_MIN: n_min++;
			OP_MAX: n_max++;
			default: n_none++;
		endcase
	endtask

	function automatic opcode_t pick_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return OP_ADD;
		else if (r < 70)
			return OP_MIN;
		else if (r < 95)
			return OP_MAX;
		return OP_NONE;
	endfunction

	// Mix full-range values with values near both ends, a dense cluster and
	// small numbers around zero, so that gaps and insertion depths vary.
	function automatic logic signed [DATA_W-1:0] pick_value(input bit dup_ok);
		case ($urandom_range(0, 7))
			0, 1: return $urandom();
			2: return 32'sh8000_0000 + $urandom_range(1, 100000);
			3: return 32'sh7FFF_FFFF - $urandom_range(1, 100000);
			4, 5: return 32'sd1000000 + $urandom_range(0, 65535);
			default: begin
				if (dup_ok && offered_vals.size() > 0)
					return offered_vals[$urandom_range(0, offered_vals.size() - 1)];
				return $signed($urandom_range(0, 255)) - 128;
			end
		endcase
	endfunction

	initial begin
		// Drive every input to a known value and hold reset.
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty set at zero capacity: adds bounce, queries lack values,
		// and the unused opcode answers with a plain zero.
		cfg_capacity('0);
		send_cmd(OP_ADD, 32'sd7);
		send_cmd(OP_MIN, 32'sd0);
		send_cmd(OP_MAX, 32'sd0);
		send_cmd(OP_NONE, -32'sd1);

		// One value only: the second add bounces, queries still lack values.
		drain_results();
		cfg_capacity(7'd1);
		send_cmd(OP_ADD, 32'sd7);
		send_cmd(OP_ADD, 32'sd9);
		send_cmd(OP_MIN, -32'sd1);
		send_cmd(OP_MAX, 32'sd0);

		// Most negative value goes in below the held one, shifting it up.
		drain_results();
		cfg_capacity(7'd2);
		send_cmd(OP_ADD, 32'sh8000_0000);
		send_cmd(OP_MIN, 32'sd0);
		send_cmd(OP_MAX, 32'sd0);

		// Most positive value gives the widest span the field can hold.
		drain_results();
		cfg_capacity(7'd4);
		send_cmd(OP_ADD, 32'sh7FFF_FFFF);
		send_cmd(OP_MAX, 32'sd0);
		send_cmd(OP_MIN, 32'sd0);
		send_cmd(OP_ADD, -32'sd1);
		send_cmd(OP_MIN, 32'sd0);
		send_cmd(OP_MAX, 32'sd0);
		send_cmd(OP_ADD, 32'sd3);
		send_cmd(OP_NONE, 32'sd0);

		// Random phases, each under its own capacity.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			cfg_capacity(CAP_W'(PHASE_CAP[p]));
			idle_on = PHASE_IDLE[p];
			if (p == DUP_PHASE) begin
				// force a repeated value: the shortest span must fall to zero
				send_cmd(OP_ADD, 32'sd7);
				send_cmd(OP_MIN, 32'sd0);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Stall the result side for a long stretch while commands keep
				// coming, so the output register fills and input backs up.
				if (p == HOLD_PHASE && n == 40)
					hold_req = 1'b1;
				// Hold off the sender until nothing is owed any more.
				if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2)
					drain_results();
				send_cmd(pick_op(), pick_value(p >= DUP_PHASE));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d adds, %0d shortest and %0d longest queries, %0d unused opcodes",
			n_add, n_min, n_max, n_none);
		$display("Checked %0d results across %0d capacity settings; set ended at %0d of %0d",
			checked, PHASES + 4, held_now, DEPTH);
		if (failures == 0 && pending == 0)
			$display("** bounded_set_span_tracker_top: PASSED **");
		else
			$display("** bounded_set_span_tracker_top: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bsst_pkg.sv
rtl/bsst_core.sv
rtl/bounded_set_span_tracker_top.sv
verif/bsst_span_checker.sv
verif/bounded_set_span_tracker_top_tb.sv
